// ----- hdl/pfc_pkg.sv -----
`default_nettype none
package pfc_pkg;

    // table geometry and alphabet size
    localparam int SYMS  = 30;
    localparam int ROWS  = 6;
    localparam int COLS  = 5;
    localparam int SYM_W = 5;
    localparam int ROW_W = 3;
    localparam int COL_W = 3;

    // marks a byte that is not in the alphabet
    localparam logic [SYM_W-1:0] NO_SYM = 5'd31;

    localparam logic [7:0] ALPHABET [SYMS] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
        8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h2C, 8'h2E, 8'h3F, 8'h3B
    };

    // request codes
    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_ADD    = 3'd1;
    localparam logic [2:0] ACT_FINISH = 3'd2;
    localparam logic [2:0] ACT_ENC    = 3'd3;
    localparam logic [2:0] ACT_DEC    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_SYM   = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_POS,
        S_CELL
    } t_ctrl_state;

    // which result the datapath loads this cycle
    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_BAD_SYM,
        RES_NOT_READY,
        RES_PAIR
    } t_res_sel;

    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     key_add;
        logic     fill_init;
        logic     fill_step;
        logic     set_ready;
        t_res_sel res;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       s1_bad;
        logic       s2_bad;
        logic       ready;
        logic       walk_last;
    } t_stat;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_rc;

    // ASCII byte to symbol index, NO_SYM when absent
    function automatic logic [SYM_W-1:0] sym_of(input logic [7:0] ch);
        logic [SYM_W-1:0] s;
        s = NO_SYM;
        for (int i = 0; i < SYMS; i++) begin
            if (ALPHABET[i] == ch) begin
                s = SYM_W'(i);
            end
        end
        return s;
    endfunction

    // symbol index to ASCII, index taken modulo the alphabet size
    function automatic logic [7:0] char_of(input logic [SYM_W-1:0] s);
        logic [SYM_W-1:0] k;
        k = (s >= SYM_W'(SYMS)) ? SYM_W'(s - SYM_W'(SYMS)) : s;
        return ALPHABET[k];
    endfunction

    // cell number to row and column
    function automatic t_rc pos_rc(input logic [SYM_W-1:0] p);
        logic [SYM_W-1:0] pp;
        t_rc              rc;
        pp = (p >= SYM_W'(SYMS)) ? SYM_W'(p - SYM_W'(SYMS)) : p;
        if (pp >= SYM_W'(5 * COLS))      rc.row = ROW_W'(5);
        else if (pp >= SYM_W'(4 * COLS)) rc.row = ROW_W'(4);
        else if (pp >= SYM_W'(3 * COLS)) rc.row = ROW_W'(3);
        else if (pp >= SYM_W'(2 * COLS)) rc.row = ROW_W'(2);
        else if (pp >= SYM_W'(COLS))     rc.row = ROW_W'(1);
        else                             rc.row = ROW_W'(0);
        rc.col = COL_W'(pp - SYM_W'(SYM_W'(rc.row) * SYM_W'(COLS)));
        return rc;
    endfunction

    // row and column to cell number
    function automatic logic [SYM_W-1:0] rc_pos(input t_rc rc);
        return SYM_W'(SYM_W'(rc.row) * SYM_W'(COLS) + SYM_W'(rc.col));
    endfunction

endpackage
`default_nettype wire

// ----- hdl/pfc_ram.sv -----
`default_nettype none
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule
`default_nettype wire

// ----- hdl/pfc_ctrl.sv -----
`default_nettype none
module pfc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pfc_pkg::t_stat i_stat,
    output logic               o_busy,
    output pfc_pkg::t_cmd      o_cmd
);

    pfc_pkg::t_ctrl_state r_state;
    pfc_pkg::t_ctrl_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfc_pkg::S_IDLE: begin
                if (i_start) n_state = pfc_pkg::S_DECODE;
            end
            pfc_pkg::S_DECODE: begin
                n_state = pfc_pkg::S_IDLE;
                unique case (i_stat.action) inside
                    pfc_pkg::ACT_FINISH: n_state = pfc_pkg::S_FILL;
                    pfc_pkg::ACT_ENC, pfc_pkg::ACT_DEC: begin
                        if (i_stat.ready && !i_stat.s1_bad && !i_stat.s2_bad) begin
                            n_state = pfc_pkg::S_POS;
                        end
                    end
                    default: n_state = pfc_pkg::S_IDLE;
                endcase
            end
            pfc_pkg::S_FILL: begin
                if (i_stat.walk_last) n_state = pfc_pkg::S_IDLE;
            end
            pfc_pkg::S_POS:  n_state = pfc_pkg::S_CELL;
            pfc_pkg::S_CELL: n_state = pfc_pkg::S_IDLE;
            default:         n_state = pfc_pkg::S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            pfc_pkg::S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            pfc_pkg::S_DECODE: begin
                unique case (i_stat.action) inside
                    pfc_pkg::ACT_CLEAR: begin
                        o_cmd.clear = 1'b1;
                        o_cmd.res   = pfc_pkg::RES_OK;
                    end
                    pfc_pkg::ACT_ADD: begin
                        o_cmd.key_add = 1'b1;
                        o_cmd.res     = i_stat.s1_bad ? pfc_pkg::RES_BAD_SYM
                                                      : pfc_pkg::RES_OK;
                    end
                    pfc_pkg::ACT_FINISH: o_cmd.fill_init = 1'b1;
                    pfc_pkg::ACT_ENC, pfc_pkg::ACT_DEC: begin
                        if (!i_stat.ready) begin
                            o_cmd.res = pfc_pkg::RES_NOT_READY;
                        end else if (i_stat.s1_bad || i_stat.s2_bad) begin
                            o_cmd.res = pfc_pkg::RES_BAD_SYM;
                        end
                    end
                    default: o_cmd.res = pfc_pkg::RES_OK;
                endcase
            end
            pfc_pkg::S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.walk_last) begin
                    o_cmd.set_ready = 1'b1;
                    o_cmd.res       = pfc_pkg::RES_OK;
                end
            end
            pfc_pkg::S_POS:  o_cmd.res = pfc_pkg::RES_NONE;
            pfc_pkg::S_CELL: o_cmd.res = pfc_pkg::RES_PAIR;
            default:         o_cmd.res = pfc_pkg::RES_NONE;
        endcase
    end

    // a fill walk always ends in a result
    a_fill_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfc_pkg::S_FILL) && i_stat.walk_last |=> (r_state == pfc_pkg::S_IDLE))
        else $error("fill walk did not return to idle");

    // a cell lookup always follows a position lookup
    a_pos_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfc_pkg::S_POS) |=> (r_state == pfc_pkg::S_CELL))
        else $error("position lookup not followed by cell lookup");

    // no request taken while busy
    a_no_capture_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> !o_cmd.capture)
        else $error("request captured while busy");

endmodule
`default_nettype wire

// ----- hdl/pfc_dp.sv -----
`default_nettype none
module pfc_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pfc_pkg::t_cmd  i_cmd,
    input  wire logic [2:0]    i_action,
    input  wire logic [7:0]    i_first_char,
    input  wire logic [7:0]    i_second_char,
    output pfc_pkg::t_stat     o_stat,
    output logic               o_strobe,
    output logic [7:0]         o_first_out,
    output logic [7:0]         o_second_out,
    output logic [1:0]         o_status
);

    localparam int SW = pfc_pkg::SYM_W;

    // captured request
    logic [2:0]    r_action;
    logic [SW-1:0] r_s1;
    logic [SW-1:0] r_s2;

    // key state
    logic [pfc_pkg::SYMS-1:0] r_used;
    logic [SW-1:0]            r_fill;
    logic                     r_ready;
    logic [SW-1:0]            r_walk;

    // result registers
    logic       r_strobe;
    logic [7:0] r_out1;
    logic [7:0] r_out2;
    logic [1:0] r_status;

    // store ports
    logic          place_req;
    logic [SW-1:0] place_sym;
    logic          place_we;
    logic [SW-1:0] pos_a;
    logic [SW-1:0] pos_b;
    logic [SW-1:0] cell_a;
    logic [SW-1:0] cell_b;
    logic [SW-1:0] q1;
    logic [SW-1:0] q2;

    pfc_pkg::t_rc rc1;
    pfc_pkg::t_rc rc2;
    pfc_pkg::t_rc nc1;
    pfc_pkg::t_rc nc2;
    logic         enc;

    assign o_stat.action    = r_action;
    assign o_stat.s1_bad    = (r_s1 == pfc_pkg::NO_SYM);
    assign o_stat.s2_bad    = (r_s2 == pfc_pkg::NO_SYM);
    assign o_stat.ready     = r_ready;
    assign o_stat.walk_last = (r_walk == SW'(pfc_pkg::SYMS - 1));

    // capture request, map bytes to symbol indices
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_s1     <= pfc_pkg::sym_of(i_first_char);
            r_s2     <= pfc_pkg::sym_of(i_second_char);
        end
    end

    // symbol to place: key character or walk index
    always_comb begin
        place_sym = i_cmd.fill_step ? r_walk : r_s1;
        place_req = 1'b0;
        if (i_cmd.fill_step) begin
            place_req = !r_used[r_walk];
        end else if (i_cmd.key_add && !o_stat.s1_bad) begin
            place_req = !r_used[r_s1];
        end
    end

    assign place_we = place_req && (r_fill < SW'(pfc_pkg::SYMS));

    // used marks, fill count, ready flag, walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_fill  <= '0;
            r_ready <= 1'b0;
            r_walk  <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_used  <= '0;
                r_fill  <= '0;
                r_ready <= 1'b0;
            end else begin
                if (place_req) r_used[place_sym] <= 1'b1;
                if (place_we)  r_fill <= SW'(r_fill + 1'b1);
                if (i_cmd.set_ready) r_ready <= 1'b1;
            end
            if (i_cmd.fill_init) begin
                r_walk <= '0;
            end else if (i_cmd.fill_step) begin
                r_walk <= SW'(r_walk + 1'b1);
            end
        end
    end

    // cell to symbol
    pfc_ram #(
        .WIDTH (SW),
        .DEPTH (pfc_pkg::SYMS)
    ) u_key_table (
        .i_clk     (i_clk),
        .i_we      (place_we),
        .i_waddr   (r_fill),
        .i_wdata   (place_sym),
        .i_raddr_a (q1),
        .i_raddr_b (q2),
        .o_rdata_a (cell_a),
        .o_rdata_b (cell_b)
    );

    // symbol to cell
    pfc_ram #(
        .WIDTH (SW),
        .DEPTH (pfc_pkg::SYMS)
    ) u_sym_pos (
        .i_clk     (i_clk),
        .i_we      (place_we),
        .i_waddr   (place_sym),
        .i_wdata   (r_fill),
        .i_raddr_a (r_s1),
        .i_raddr_b (r_s2),
        .o_rdata_a (pos_a),
        .o_rdata_b (pos_b)
    );

    // pair rule: same row, same column, or rectangle
    always_comb begin
        enc = (r_action == pfc_pkg::ACT_ENC);
        rc1 = pfc_pkg::pos_rc(pos_a);
        rc2 = pfc_pkg::pos_rc(pos_b);
        nc1 = rc1;
        nc2 = rc2;
        if (rc1.row == rc2.row) begin
            if (enc) begin
                nc1.col = (rc1.col == 3'(pfc_pkg::COLS - 1)) ? '0 : 3'(rc1.col + 1'b1);
                nc2.col = (rc2.col == 3'(pfc_pkg::COLS - 1)) ? '0 : 3'(rc2.col + 1'b1);
            end else begin
                nc1.col = (rc1.col == '0) ? 3'(pfc_pkg::COLS - 1) : 3'(rc1.col - 1'b1);
                nc2.col = (rc2.col == '0) ? 3'(pfc_pkg::COLS - 1) : 3'(rc2.col - 1'b1);
            end
        end else if (rc1.col == rc2.col) begin
            if (enc) begin
                nc1.row = (rc1.row == 3'(pfc_pkg::ROWS - 1)) ? '0 : 3'(rc1.row + 1'b1);
                nc2.row = (rc2.row == 3'(pfc_pkg::ROWS - 1)) ? '0 : 3'(rc2.row + 1'b1);
            end else begin
                nc1.row = (rc1.row == '0) ? 3'(pfc_pkg::ROWS - 1) : 3'(rc1.row - 1'b1);
                nc2.row = (rc2.row == '0) ? 3'(pfc_pkg::ROWS - 1) : 3'(rc2.row - 1'b1);
            end
        end else begin
            nc1.col = rc2.col;
            nc2.col = rc1.col;
        end
        q1 = pfc_pkg::rc_pos(nc1);
        q2 = pfc_pkg::rc_pos(nc2);
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.res != pfc_pkg::RES_NONE);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.res)
            pfc_pkg::RES_PAIR: begin
                r_out1   <= pfc_pkg::char_of(cell_a);
                r_out2   <= pfc_pkg::char_of(cell_b);
                r_status <= pfc_pkg::ST_OK;
            end
            pfc_pkg::RES_BAD_SYM: begin
                r_out1   <= '0;
                r_out2   <= '0;
                r_status <= pfc_pkg::ST_BAD_SYM;
            end
            pfc_pkg::RES_NOT_READY: begin
                r_out1   <= '0;
                r_out2   <= '0;
                r_status <= pfc_pkg::ST_NOT_READY;
            end
            pfc_pkg::RES_OK: begin
                r_out1   <= '0;
                r_out2   <= '0;
                r_status <= pfc_pkg::ST_OK;
            end
            default: ;
        endcase
    end

    assign o_strobe     = r_strobe;
    assign o_first_out  = r_out1;
    assign o_second_out = r_out2;
    assign o_status     = r_status;

    // a finished table has every symbol placed
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> ((&r_used) && (r_fill == SW'(pfc_pkg::SYMS))))
        else $error("table ready but not full");

    // fill count never passes the table size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SW'(pfc_pkg::SYMS))
        else $error("fill count overflow");

    // a transformed pair only comes from a finished table
    a_pair_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && (r_out1 != 8'd0) |-> r_ready)
        else $error("pair result without finished table");

endmodule
`default_nettype wire

// ----- hdl/playfair_cipher_6x5.sv -----
`default_nettype none
// Playfair cipher on a 6 by 5 table over A-Z , . ? ;
// Request channel: start is sampled with action, first_char and second_char;
// a request is taken at a rising edge with start high and busy low.
// Actions: clear key, add key character, finish table, encrypt pair,
// decrypt pair. Every request gives exactly one result.
// Result channel: o_first_out, o_second_out and o_status are valid for the
// single cycle in which o_strobe is high. The receiver cannot stall; a
// result is shown once and then replaced only by the next one.
// Clear, add and unused codes, and pairs rejected on status, give their
// result straight from the decode state; a transformed pair passes a
// position state and then a cell state (symbol-to-cell read, then
// cell-to-symbol read, each a registered RAM port); finish runs a decode
// state, a walk over all 30 symbols one per cycle, then the strobe cycle.
// busy falls in the strobe cycle, so a new request may be taken then.
// Reset (synchronous, active low) clears used marks, fill count and the
// ready flag; the table stores hold no defined contents until written.
module playfair_cipher_6x5 (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_action,
    input  wire logic [7:0] i_first_char,
    input  wire logic [7:0] i_second_char,
    output logic            o_strobe,
    output logic [7:0]      o_first_out,
    output logic [7:0]      o_second_out,
    output logic [1:0]      o_status
);

    pfc_pkg::t_cmd  cmd;
    pfc_pkg::t_stat stat;

    // sequencer
    pfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // key stores and pair logic
    pfc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_first_char  (i_first_char),
        .i_second_char (i_second_char),
        .o_stat        (stat),
        .o_strobe      (o_strobe),
        .o_first_out   (o_first_out),
        .o_second_out  (o_second_out),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire

// ----- tb/sv/playfair_cipher_6x5_tb.sv -----
`timescale 1ns / 100ps

module playfair_cipher_6x5_tb;
    import pfc_pkg::*;

    // action codes the block leaves unused
    localparam logic [2:0] ACT_UNUSED5 = 3'd5;
    localparam logic [2:0] ACT_UNUSED6 = 3'd6;
    localparam logic [2:0] ACT_UNUSED7 = 3'd7;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int TAIL_CYCLES     = 40;
    localparam int RUN_LIMIT       = 600000;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [8*SYMS-1:0] GLYPHS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ,.?;";

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] status;
    } cipher_out_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_a;
        logic [7:0]  char_b;
        logic        typed;
        cipher_out_t result;
    } directed_row_t;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       start         = 1'b0;
    logic [2:0] i_action      = '0;
    logic [7:0] i_first_char  = '0;
    logic [7:0] i_second_char = '0;
    logic       busy;
    logic       o_strobe;
    logic [7:0] o_first_out;
    logic [7:0] o_second_out;
    logic [1:0] o_status;

    // predictor copy of the key table
    logic [SYM_W-1:0] grid [SYMS];
    logic [SYM_W-1:0] where_is [SYMS];
    bit               placed [SYMS];
    int               filled;
    bit               grid_ready;

    cipher_out_t   awaited_outputs [$];
    directed_row_t directed_rows [$];
    int            fault_count = 0;
    int            issued      = 0;
    int            cycle_count = 0;
    bit            burst_mode  = 1'b0;

    playfair_cipher_6x5 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_first_char  (i_first_char),
        .i_second_char (i_second_char),
        .o_strobe      (o_strobe),
        .o_first_out   (o_first_out),
        .o_second_out  (o_second_out),
        .o_status      (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // watchdog
    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] glyph(input int idx);
        return GLYPHS[8*(SYMS-1-idx) +: 8];
    endfunction

    function automatic logic [SYM_W-1:0] glyph_index(input logic [7:0] ch);
        logic [SYM_W-1:0] idx;
        idx = NO_SYM;
        for (int i = 0; i < SYMS; i++) begin
            if (glyph(i) == ch) begin
                idx = SYM_W'(i);
            end
        end
        return idx;
    endfunction

    // symbol in the cell at row/col, both wrapped
    function automatic logic [7:0] glyph_at(input int row, input int col);
        return glyph(int'(grid[(row % ROWS) * COLS + (col % COLS)]));
    endfunction

    task automatic place_symbol(input int s);
        if (filled < SYMS) begin
            grid[filled] = SYM_W'(s);
            where_is[s]  = SYM_W'(filled);
            filled++;
        end
        placed[s] = 1'b1;
    endtask

    // one request applied to the predicted key table
    task automatic playfair_step(input logic [2:0] act, input logic [7:0] ch_a,
                                 input logic [7:0] ch_b, output cipher_out_t res);
        logic [SYM_W-1:0] s1;
        logic [SYM_W-1:0] s2;
        int               p1, p2, r1, r2, k1, k2, shift;
        res = '0;
        s1  = glyph_index(ch_a);
        s2  = glyph_index(ch_b);
        case (act)
            ACT_CLEAR: begin
                for (int i = 0; i < SYMS; i++) placed[i] = 1'b0;
                filled     = 0;
                grid_ready = 1'b0;
            end
            ACT_ADD: begin
                if (s1 == NO_SYM) begin
                    res.status = ST_BAD_SYM;
                end else if (!placed[s1]) begin
                    place_symbol(int'(s1));
                end
            end
            ACT_FINISH: begin
                for (int i = 0; i < SYMS; i++) begin
                    if (!placed[i]) place_symbol(i);
                end
                grid_ready = 1'b1;
            end
            ACT_ENC, ACT_DEC: begin
                if (!grid_ready) begin
                    res.status = ST_NOT_READY;
                end else if (s1 == NO_SYM || s2 == NO_SYM) begin
                    res.status = ST_BAD_SYM;
                end else begin
                    p1 = int'(where_is[s1]);
                    p2 = int'(where_is[s2]);
                    r1 = p1 / COLS;
                    k1 = p1 % COLS;
                    r2 = p2 / COLS;
                    k2 = p2 % COLS;
                    if (r1 == r2) begin
                        shift      = (act == ACT_ENC) ? 1 : COLS - 1;
                        res.first  = glyph_at(r1, k1 + shift);
                        res.second = glyph_at(r2, k2 + shift);
                    end else if (k1 == k2) begin
                        shift      = (act == ACT_ENC) ? 1 : ROWS - 1;
                        res.first  = glyph_at(r1 + shift, k1);
                        res.second = glyph_at(r2 + shift, k2);
                    end else begin
                        res.first  = glyph_at(r1, k2);
                        res.second = glyph_at(r2, k1);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // mostly short gaps, a few long ones, none in burst mode
    function automatic int pick_gap();
        int r;
        if (burst_mode) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    function automatic logic [7:0] rand_glyph();
        return glyph($urandom_range(SYMS - 1));
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    task automatic send_request(input logic [2:0] act, input logic [7:0] ch_a,
                                input logic [7:0] ch_b, input logic typed,
                                input cipher_out_t typed_res);
        cipher_out_t predicted;
        int          gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_action      <= act;
        i_first_char  <= ch_a;
        i_second_char <= ch_b;
        do @(posedge i_clk); while (busy !== 1'b0);
        playfair_step(act, ch_a, ch_b, predicted);
        awaited_outputs.push_back(typed ? typed_res : predicted);
        issued++;
    endtask

    task automatic send(input logic [2:0] act, input logic [7:0] ch_a,
                        input logic [7:0] ch_b);
        send_request(act, ch_a, ch_b, 1'b0, '0);
    endtask

    // hold off until every result is back
    task automatic drain_results();
        start <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
    endtask

    // result checker
    always @(posedge i_clk) begin
        cipher_out_t want;
        if (i_rst_n && o_strobe) begin
            if (awaited_outputs.size() == 0) begin
                note_fault($sformatf("unexpected result %h %h status %0d",
                                     o_first_out, o_second_out, o_status));
            end else begin
                want = awaited_outputs.pop_front();
                if (o_first_out !== want.first || o_second_out !== want.second ||
                    o_status !== want.status) begin
                    note_fault($sformatf("expected %h %h status %0d, got %h %h status %0d",
                                         want.first, want.second, want.status,
                                         o_first_out, o_second_out, o_status));
                end
            end
        end
    end

    // random key session: clear (mostly), key characters, finish (mostly), then pairs
    task automatic key_session();
        int n_keys, n_pairs, r;
        burst_mode = ($urandom_range(3) == 0);
        if ($urandom_range(9) != 0) send(ACT_CLEAR, rand_byte(), rand_byte());
        n_keys = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10);
        repeat (n_keys) begin
            send(ACT_ADD, ($urandom_range(99) < 85) ? rand_glyph() : rand_byte(), rand_byte());
        end
        if ($urandom_range(9) != 0) send(ACT_FINISH, rand_byte(), rand_byte());
        n_pairs = $urandom_range(24, 3);
        repeat (n_pairs) begin
            r = $urandom_range(99);
            if (r < 88) begin
                send($urandom_range(1) ? ACT_ENC : ACT_DEC, rand_glyph(), rand_glyph());
            end else if (r < 94) begin
                send($urandom_range(1) ? ACT_ENC : ACT_DEC,
                     $urandom_range(1) ? rand_byte() : rand_glyph(),
                     $urandom_range(1) ? rand_byte() : rand_glyph());
            end else begin
                // stray request inside the pair stream
                send(3'($urandom_range(7)), rand_glyph(), rand_byte());
            end
        end
    endtask

    task automatic noise_burst();
        burst_mode = ($urandom_range(3) == 0);
        repeat ($urandom_range(8, 1)) send(3'($urandom), rand_byte(), rand_byte());
    endtask

    initial begin
        // after reset, extremes and error codes have known results;
        // the table is P L A Y ; / B C D E F / G H I J K / M N O Q R / ...
        directed_rows.push_back('{ACT_ENC, "A", "B", 1'b1, '{8'd0, 8'd0, ST_NOT_READY}});
        directed_rows.push_back('{ACT_DEC, 8'h00, 8'hFF, 1'b1, '{8'd0, 8'd0, ST_NOT_READY}});
        directed_rows.push_back('{ACT_ADD, 8'h00, 8'h00, 1'b1, '{8'd0, 8'd0, ST_BAD_SYM}});
        directed_rows.push_back('{ACT_ADD, 8'hFF, 8'hFF, 1'b1, '{8'd0, 8'd0, ST_BAD_SYM}});
        directed_rows.push_back('{ACT_UNUSED7, 8'hFF, 8'hFF, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_UNUSED5, "A", "B", 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_UNUSED6, "?", ";", 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_CLEAR, 8'h00, 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ADD, "P", 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ADD, "L", 8'hFF, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ADD, "A", 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ADD, "Y", 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        // repeated key character is dropped
        directed_rows.push_back('{ACT_ADD, "P", 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ADD, ";", 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ADD, "a", 8'h00, 1'b1, '{8'd0, 8'd0, ST_BAD_SYM}});
        directed_rows.push_back('{ACT_FINISH, 8'h00, 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_FINISH, 8'hFF, 8'hFF, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ADD, "Z", 8'h00, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ENC, "A", 8'h00, 1'b1, '{8'd0, 8'd0, ST_BAD_SYM}});
        directed_rows.push_back('{ACT_DEC, 8'hFF, "A", 1'b1, '{8'd0, 8'd0, ST_BAD_SYM}});
        // same row, same column with wrap, rectangle, equal pair
        directed_rows.push_back('{ACT_ENC, "P", ";", 1'b0, '0});
        directed_rows.push_back('{ACT_ENC, "L", "Z", 1'b0, '0});
        directed_rows.push_back('{ACT_DEC, "P", "W", 1'b0, '0});
        directed_rows.push_back('{ACT_ENC, "Q", "Q", 1'b0, '0});
        directed_rows.push_back('{ACT_DEC, ";", "P", 1'b0, '0});
        directed_rows.push_back('{ACT_CLEAR, 8'hFF, 8'hFF, 1'b1, '{8'd0, 8'd0, ST_OK}});
        directed_rows.push_back('{ACT_ENC, "A", "B", 1'b1, '{8'd0, 8'd0, ST_NOT_READY}});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < SYMS; i++) placed[i] = 1'b0;
        filled     = 0;
        grid_ready = 1'b0;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].action, directed_rows[i].char_a,
                         directed_rows[i].char_b, directed_rows[i].typed,
                         directed_rows[i].result);
        end
        drain_results();

        // random part: mostly well-formed key sessions, some noise
        while (issued < directed_rows.size() + RANDOM_REQUESTS) begin
            if ($urandom_range(99) < 85) key_session();
            else noise_burst();
            if ($urandom_range(9) == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
